[hw/rtl/assert_macros.svh]
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

[hw/rtl/psd_pkg.sv]
// ----------------------------------------------------------------------------
// psd_pkg
// types and constants for the point to segment distance unit
// ----------------------------------------------------------------------------
package psd_pkg;
  localparam int COORD_BITS = 24;
  localparam int FRAC_BITS  = 16;
  localparam int DIST_BITS  = 50;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int DOT_BITS   = PROD_BITS + 1;
  localparam int Q_BITS     = FRAC_BITS;
  localparam int QD_BITS    = 4;
  localparam int QD_LOG     = 2;

  typedef enum logic [1:0] {
    REG_START  = 2'd0,
    REG_END    = 2'd1,
    REG_INNER  = 2'd2
  } region_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
  } psd_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] near_x;
    logic signed [COORD_BITS-1:0] near_y;
    logic [DIST_BITS-1:0]         dist_sq;
    logic [1:0]                   region;
  } psd_out_t;

  // classified job handed from front to back
  typedef struct packed {
    psd_in_t                 item;
    region_t                 region;
    logic [DOT_BITS-2:0]     num;
    logic [DOT_BITS-2:0]     den;
  } psd_job_t;

  // queue status between modules
  typedef struct packed {
    logic empty;
    logic full;
  } psd_qstat_t;
endpackage

[hw/rtl/psd_front.sv]
// ----------------------------------------------------------------------------
// psd_front
// two-stage classifier: differences, products, dot products and region
// ----------------------------------------------------------------------------
module psd_front import psd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  psd_in_t  in_data,
  output logic     job_valid,
  input  logic     job_ready,
  output psd_job_t job_data
);
  logic     s1_vld_r, s2_vld_r;
  psd_in_t  s1_item_r, s2_item_r;
  logic signed [PROD_BITS-1:0] pxx_r, pyy_r, vxx_r, vyy_r;
  logic signed [DIFF_BITS-1:0] vx, vy, wx, wy;
  logic signed [DOT_BITS-1:0]  n_val, d_val;
  logic adv2, adv1;

  assign adv2 = !s2_vld_r || job_ready;
  assign adv1 = !s1_vld_r || adv2;
  assign in_ready = adv1;

  // differences
  always_comb begin
    vx = DIFF_BITS'(in_data.end_x) - DIFF_BITS'(in_data.start_x);
    vy = DIFF_BITS'(in_data.end_y) - DIFF_BITS'(in_data.start_y);
    wx = DIFF_BITS'(in_data.point_x) - DIFF_BITS'(in_data.start_x);
    wy = DIFF_BITS'(in_data.point_y) - DIFF_BITS'(in_data.start_y);
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv1) begin
      s1_vld_r <= in_valid;
    end
    if (adv1 && in_valid) begin
      s1_item_r <= in_data;
      pxx_r <= PROD_BITS'(wx) * PROD_BITS'(vx);
      pyy_r <= PROD_BITS'(wy) * PROD_BITS'(vy);
      vxx_r <= PROD_BITS'(vx) * PROD_BITS'(vx);
      vyy_r <= PROD_BITS'(vy) * PROD_BITS'(vy);
    end
  end

  // stage 2: sums and classification
  assign n_val = DOT_BITS'(pxx_r) + DOT_BITS'(pyy_r);
  assign d_val = DOT_BITS'(vxx_r) + DOT_BITS'(vyy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv2) begin
      s2_vld_r <= s1_vld_r;
    end
    if (adv2 && s1_vld_r) begin
      job_data.item <= s1_item_r;
      job_data.num  <= n_val[DOT_BITS-2:0];
      job_data.den  <= d_val[DOT_BITS-2:0];
      if (n_val <= 0)          job_data.region <= REG_START;
      else if (d_val <= n_val) job_data.region <= REG_END;
      else                     job_data.region <= REG_INNER;
    end
  end
  assign job_valid = s2_vld_r;
endmodule

[hw/rtl/psd_queue.sv]
// ----------------------------------------------------------------------------
// psd_queue
// small fifo between the classifier and the execute pipeline
// ----------------------------------------------------------------------------
module psd_queue import psd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_valid,
  output logic       wr_ready,
  input  psd_job_t   wr_data,
  output logic       rd_valid,
  input  logic       rd_ready,
  output psd_job_t   rd_data,
  output psd_qstat_t stat
);
  psd_job_t mem_r [QD_BITS];
  logic [QD_LOG-1:0] wp_r, rp_r;
  logic [QD_LOG:0]   cnt_r;
  logic wr_fire, rd_fire;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == (QD_LOG+1)'(QD_BITS));
  assign wr_ready = !stat.full;
  assign rd_valid = !stat.empty;
  assign rd_data  = mem_r[rp_r];
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = rd_valid && rd_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_fire) wp_r <= wp_r + 1'b1;
      if (rd_fire) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QD_LOG+1)'(wr_fire) - (QD_LOG+1)'(rd_fire);
    end
    if (wr_fire) mem_r[wp_r] <= wr_data;
  end
endmodule

[hw/rtl/psd_back.sv]
// ----------------------------------------------------------------------------
// psd_back
// pipelined restoring divider, projection and squared distance
// ----------------------------------------------------------------------------
module psd_back import psd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     job_valid,
  output logic     job_ready,
  input  psd_job_t job_data,
  output logic     out_valid,
  input  logic     out_ready,
  output psd_out_t out_data
);
  localparam int NS = Q_BITS + 4;
  localparam int RB = DOT_BITS;

  logic           vld_r  [NS];
  psd_job_t       job_r  [NS];
  logic [RB-1:0]  rem_r  [Q_BITS+1];
  logic [Q_BITS-1:0] q_r [Q_BITS+1];
  logic signed [PROD_BITS+Q_BITS:0] mx_r, my_r;
  logic signed [COORD_BITS-1:0] cx_r, cy_r;
  logic signed [DIFF_BITS-1:0] dx, dy;
  logic [PROD_BITS-1:0] dxx_r, dyy_r;
  logic signed [COORD_BITS-1:0] near_x_r, near_y_r;
  logic [1:0] region_r;
  logic adv;

  // whole pipe stalls together; final stage doubles as output register
  assign adv = !vld_r[NS-1] || out_ready;
  assign job_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= job_valid;
      for (int i = 1; i < NS; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // divider: one quotient bit per stage
  always_ff @(posedge clk) begin
    logic [RB-1:0] r;
    if (adv) begin
      job_r[0] <= job_data;
      rem_r[0] <= RB'(job_data.num);
      q_r[0]   <= '0;
      for (int i = 1; i <= Q_BITS; i++) begin
        job_r[i] <= job_r[i-1];
        r = {rem_r[i-1][RB-2:0], 1'b0};
        if (r >= RB'(job_r[i-1].den)) begin
          rem_r[i] <= r - RB'(job_r[i-1].den);
          q_r[i]   <= {q_r[i-1][Q_BITS-2:0], 1'b1};
        end else begin
          rem_r[i] <= r;
          q_r[i]   <= {q_r[i-1][Q_BITS-2:0], 1'b0};
        end
      end
      for (int i = Q_BITS+1; i < NS; i++) job_r[i] <= job_r[i-1];
    end
  end

  // projection multiply
  always_ff @(posedge clk) begin
    if (adv) begin
      mx_r <= (PROD_BITS+Q_BITS+1)'(DIFF_BITS'(job_r[Q_BITS].item.end_x)
              - DIFF_BITS'(job_r[Q_BITS].item.start_x))
              * $signed({1'b0, q_r[Q_BITS]});
      my_r <= (PROD_BITS+Q_BITS+1)'(DIFF_BITS'(job_r[Q_BITS].item.end_y)
              - DIFF_BITS'(job_r[Q_BITS].item.start_y))
              * $signed({1'b0, q_r[Q_BITS]});
    end
  end

  // closest point select
  always_ff @(posedge clk) begin
    psd_in_t it;
    it = job_r[Q_BITS+1].item;
    if (adv) begin
      case (job_r[Q_BITS+1].region)
        REG_START: begin cx_r <= it.start_x; cy_r <= it.start_y; end
        REG_END:   begin cx_r <= it.end_x;   cy_r <= it.end_y;   end
        default: begin
          cx_r <= it.start_x + COORD_BITS'(mx_r >>> FRAC_BITS);
          cy_r <= it.start_y + COORD_BITS'(my_r >>> FRAC_BITS);
        end
      endcase
    end
  end

  // squared distance terms
  assign dx = DIFF_BITS'(job_r[Q_BITS+2].item.point_x) - DIFF_BITS'(cx_r);
  assign dy = DIFF_BITS'(job_r[Q_BITS+2].item.point_y) - DIFF_BITS'(cy_r);
  always_ff @(posedge clk) begin
    if (adv) begin
      dxx_r    <= PROD_BITS'(PROD_BITS'(dx) * PROD_BITS'(dx));
      dyy_r    <= PROD_BITS'(PROD_BITS'(dy) * PROD_BITS'(dy));
      near_x_r <= cx_r;
      near_y_r <= cy_r;
      region_r <= 2'(job_r[Q_BITS+2].region);
    end
  end

  // result transfer payload
  assign out_data = '{near_x: near_x_r, near_y: near_y_r,
                      dist_sq: DIST_BITS'(dxx_r + dyy_r), region: region_r};
  assign out_valid = vld_r[NS-1];
endmodule

[hw/rtl/point_segment_distance_unit.sv]
// throughput: one item per cycle while out_ready does not stall the pipes
// the execute pipe after the classifier and queue takes one quotient bit a stage
// reset: synchronous active-low rst_n empties all pipes and the queue
// ----------------------------------------------------------------------------
// point_segment_distance_unit
// closest point on a segment and squared distance, fixed-point projection
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module point_segment_distance_unit import psd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  psd_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output psd_out_t out_data
);
  logic       f_valid, f_ready, q_valid, q_ready;
  psd_job_t   f_data, q_data;
  psd_qstat_t q_stat;

  psd_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .job_valid(f_valid), .job_ready(f_ready), .job_data(f_data)
  );

  psd_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data),
    .stat(q_stat)
  );

  psd_back u_back (
    .clk, .rst_n,
    .job_valid(q_valid), .job_ready(q_ready), .job_data(q_data),
    .out_valid, .out_ready, .out_data
  );

  `ASSERT_IMPLIES(a_region_legal, clk, rst_n, out_valid, out_data.region != 2'd3)
  `ASSERT_IMPLIES(a_q_status, clk, rst_n, q_stat.full, !q_stat.empty)
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule
